/* sv/tcw_pkg.sv */
package tcw_pkg;

   // field widths of the channels
   localparam int KIND_W     = 2;
   localparam int CHAR_W     = 8;
   localparam int COLOR_W    = 8;
   localparam int CELL_ROW_W = 5;
   localparam int CELL_COL_W = 7;
   localparam int CUR_ROW_W  = 5;
   localparam int CUR_COL_W  = 7;
   localparam int LOC_W      = 11;
   localparam int CELL_W     = CHAR_W + COLOR_W;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

   // special character codes
   localparam logic [CHAR_W-1:0] NULL_CODE    = 8'd0;
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

   typedef enum logic [1:0] {
      WD_ZERO,
      WD_CELL,
      WD_COPY
   } wdata_sel_type;

   typedef enum logic {
      WA_SWEEP,
      WA_CURSOR
   } waddr_sel_type;

   typedef enum logic {
      RA_CELL,
      RA_AHEAD
   } raddr_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_ZERO,
      CNT_INC
   } cnt_op_type;

   typedef struct packed {
      logic          load_item;
      logic          ram_we;
      wdata_sel_type wd_sel;
      waddr_sel_type wa_sel;
      logic          ram_re;
      raddr_sel_type ra_sel;
      cnt_op_type    cnt_op;
      logic          cur_adv;
      logic          cur_home;
      logic          rd_cap;
      logic          rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              char_null;
      logic              char_newline;
      logic              adv_scrolls;
      logic              rd_in_range;
      logic              sweep_last;
      logic              copy_last;
      logic              rsp_free;
   } sts_type;

endpackage

/* sv/tcw_ram.sv */
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1920
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* sv/tcw_ctrl.sv */
module tcw_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tcw_pkg::sts_type sts,
   output tcw_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_CLEAR,
      ST_READ_WAIT,
      ST_SCROLL_PRIME,
      ST_SCROLL_COPY,
      ST_SCROLL_ZERO,
      ST_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            // power-on clear of the screen store
            cmd.ram_we = 1'b1;
            cmd.wd_sel = tcw_pkg::WD_ZERO;
            cmd.wa_sel = tcw_pkg::WA_SWEEP;
            cmd.cnt_op = tcw_pkg::CNT_INC;
            if (sts.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (sts.kind)
               tcw_pkg::KIND_APPEND: begin
                  if (sts.char_null) begin
                     state_in = ST_RESP;
                  end else begin
                     cmd.ram_we  = !sts.char_newline;
                     cmd.wd_sel  = tcw_pkg::WD_CELL;
                     cmd.wa_sel  = tcw_pkg::WA_CURSOR;
                     cmd.cur_adv = 1'b1;
                     state_in    = sts.adv_scrolls ? ST_SCROLL_PRIME : ST_RESP;
                  end
               end
               tcw_pkg::KIND_CLEAR: begin
                  cmd.cnt_op   = tcw_pkg::CNT_ZERO;
                  cmd.cur_home = 1'b1;
                  state_in     = ST_CLEAR;
               end
               tcw_pkg::KIND_READ: begin
                  if (sts.rd_in_range) begin
                     cmd.ram_re = 1'b1;
                     cmd.ra_sel = tcw_pkg::RA_CELL;
                     state_in   = ST_READ_WAIT;
                  end else begin
                     state_in = ST_RESP;
                  end
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_CLEAR: begin
            cmd.ram_we = 1'b1;
            cmd.wd_sel = tcw_pkg::WD_ZERO;
            cmd.wa_sel = tcw_pkg::WA_SWEEP;
            cmd.cnt_op = tcw_pkg::CNT_INC;
            if (sts.sweep_last) begin
               state_in = ST_RESP;
            end
         end
         ST_READ_WAIT: begin
            cmd.rd_cap = 1'b1;
            state_in   = ST_RESP;
         end
         ST_SCROLL_PRIME: begin
            // fetch the first cell of row 1
            cmd.cnt_op = tcw_pkg::CNT_ZERO;
            cmd.ram_re = 1'b1;
            cmd.ra_sel = tcw_pkg::RA_AHEAD;
            state_in   = ST_SCROLL_COPY;
         end
         ST_SCROLL_COPY: begin
            cmd.ram_we = 1'b1;
            cmd.wd_sel = tcw_pkg::WD_COPY;
            cmd.wa_sel = tcw_pkg::WA_SWEEP;
            cmd.cnt_op = tcw_pkg::CNT_INC;
            cmd.ram_re = !sts.copy_last;
            cmd.ra_sel = tcw_pkg::RA_AHEAD;
            if (sts.copy_last) begin
               state_in = ST_SCROLL_ZERO;
            end
         end
         ST_SCROLL_ZERO: begin
            cmd.ram_we = 1'b1;
            cmd.wd_sel = tcw_pkg::WD_ZERO;
            cmd.wa_sel = tcw_pkg::WA_SWEEP;
            cmd.cnt_op = tcw_pkg::CNT_INC;
            if (sts.sweep_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/tcw_dpath.sv */
module tcw_dpath #(
   parameter int SCREEN_ROWS = 24,
   parameter int SCREEN_COLS = 80
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [tcw_pkg::KIND_W-1:0]       req_kind,
   input  logic [tcw_pkg::CHAR_W-1:0]       req_char_code,
   input  logic [tcw_pkg::COLOR_W-1:0]      req_color,
   input  logic [tcw_pkg::CELL_ROW_W-1:0]   req_cell_row,
   input  logic [tcw_pkg::CELL_COL_W-1:0]   req_cell_col,
   input  tcw_pkg::cmd_type                 cmd,
   output tcw_pkg::sts_type                 sts,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tcw_pkg::CUR_ROW_W-1:0]    rsp_cursor_row,
   output logic [tcw_pkg::CUR_COL_W-1:0]    rsp_cursor_col,
   output logic [tcw_pkg::LOC_W-1:0]        rsp_cursor_location,
   output logic [tcw_pkg::CHAR_W-1:0]       rsp_read_char,
   output logic [tcw_pkg::COLOR_W-1:0]      rsp_read_color
);

   localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(SCREEN_ROWS);
   localparam int CW    = $clog2(SCREEN_COLS);

   // item registers
   logic [tcw_pkg::KIND_W-1:0]     kind_ff;
   logic [tcw_pkg::CHAR_W-1:0]     char_ff;
   logic [tcw_pkg::COLOR_W-1:0]    color_ff;
   logic [tcw_pkg::CELL_ROW_W-1:0] crow_ff;
   logic [tcw_pkg::CELL_COL_W-1:0] ccol_ff;

   // cursor and sweep counter
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [AW-1:0] idx_ff, idx_in;

   logic [tcw_pkg::CELL_W-1:0] rd_ff;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::CUR_ROW_W-1:0] rsp_row_ff;
   logic [tcw_pkg::CUR_COL_W-1:0] rsp_col_ff;
   logic [tcw_pkg::LOC_W-1:0]     rsp_loc_ff;
   logic [tcw_pkg::CELL_W-1:0]    rsp_cell_ff;

   logic [AW-1:0] loc;
   logic [AW-1:0] cell_addr;
   logic [AW-1:0] ahead_addr;
   logic          col_last, row_last, newline, wraps;

   logic                       ram_we, ram_re;
   logic [AW-1:0]              ram_waddr, ram_raddr;
   logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

   assign loc        = AW'(int'(row_ff) * SCREEN_COLS + int'(col_ff));
   assign cell_addr  = AW'(int'(crow_ff) * SCREEN_COLS + int'(ccol_ff));
   assign ahead_addr = AW'(int'(idx_in) + SCREEN_COLS);

   assign col_last = (col_ff == CW'(SCREEN_COLS - 1));
   assign row_last = (row_ff == RW'(SCREEN_ROWS - 1));
   assign newline  = (char_ff == tcw_pkg::NEWLINE_CODE);
   assign wraps    = newline || col_last;

   always_comb begin
      sts.kind         = kind_ff;
      sts.char_null    = (char_ff == tcw_pkg::NULL_CODE);
      sts.char_newline = newline;
      sts.adv_scrolls  = wraps && row_last;
      sts.rd_in_range  = (int'(crow_ff) < SCREEN_ROWS) && (int'(ccol_ff) < SCREEN_COLS);
      sts.sweep_last   = (idx_ff == AW'(CELLS - 1));
      sts.copy_last    = (idx_ff == AW'(CELLS - SCREEN_COLS - 1));
      sts.rsp_free     = !rsp_valid_ff || !rsp_stall;
   end

   // cursor step; row holds on the bottom row when a scroll follows
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.cur_home) begin
         row_in = '0;
         col_in = '0;
      end else if (cmd.cur_adv) begin
         if (wraps) begin
            col_in = '0;
            if (!row_last) begin
               row_in = row_ff + RW'(1);
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_comb begin
      case (cmd.cnt_op)
         tcw_pkg::CNT_ZERO: idx_in = '0;
         tcw_pkg::CNT_INC:  idx_in = idx_ff + AW'(1);
         default:           idx_in = idx_ff;
      endcase
   end

   // screen store port muxing
   always_comb begin
      ram_we    = cmd.ram_we;
      ram_re    = cmd.ram_re;
      ram_waddr = (cmd.wa_sel == tcw_pkg::WA_CURSOR) ? loc : idx_ff;
      ram_raddr = (cmd.ra_sel == tcw_pkg::RA_CELL) ? cell_addr : ahead_addr;
      case (cmd.wd_sel)
         tcw_pkg::WD_CELL: ram_wdata = {color_ff, char_ff};
         tcw_pkg::WD_COPY: ram_wdata = ram_rdata;
         default:          ram_wdata = '0;
      endcase
   end

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff  <= req_kind;
         char_ff  <= req_char_code;
         color_ff <= req_color;
         crow_ff  <= req_cell_row;
         ccol_ff  <= req_cell_col;
      end
      if (cmd.load_item) begin
         rd_ff <= '0;
      end else if (cmd.rd_cap) begin
         rd_ff <= ram_rdata;
      end
      if (cmd.rsp_load) begin
         rsp_row_ff  <= tcw_pkg::CUR_ROW_W'(row_ff);
         rsp_col_ff  <= tcw_pkg::CUR_COL_W'(col_ff);
         rsp_loc_ff  <= tcw_pkg::LOC_W'(loc);
         rsp_cell_ff <= rd_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_row      = rsp_row_ff;
   assign rsp_cursor_col      = rsp_col_ff;
   assign rsp_cursor_location = rsp_loc_ff;
   assign rsp_read_char       = rsp_cell_ff[tcw_pkg::CHAR_W-1:0];
   assign rsp_read_color      = rsp_cell_ff[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];

endmodule

/* sv/text_console_writer_top.sv */
// Text console writer: a SCREEN_ROWS x SCREEN_COLS store of 16-bit cells
// (character in the low byte, color in the high byte) plus a cursor. Kind 0
// appends a character at the cursor (newline moves to the next row, a null
// character does nothing, running off the bottom scrolls the screen up one
// row), kind 1 clears the screen and homes the cursor, kind 2 reads one cell;
// kind 3 does nothing. Every transfer on req_ gives one transfer on rsp_ with
// the cursor after the item and its linear location. Items are handled one at
// a time; the result sits in an output register, so the next item is taken
// while an earlier result still waits. Clears and scrolling appends are the
// long items: they go through the single write port of the screen RAM, which
// copies or zeroes one cell a cycle. After reset a clearing pass over every
// cell runs with req_stall high.
module text_console_writer_top #(
   parameter int SCREEN_ROWS = 24,
   parameter int SCREEN_COLS = 80
) (
   input  logic                             clock,
   input  logic                             reset,

   // item channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tcw_pkg::KIND_W-1:0]       req_kind,
   input  logic [tcw_pkg::CHAR_W-1:0]       req_char_code,
   input  logic [tcw_pkg::COLOR_W-1:0]      req_color,
   input  logic [tcw_pkg::CELL_ROW_W-1:0]   req_cell_row,
   input  logic [tcw_pkg::CELL_COL_W-1:0]   req_cell_col,

   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tcw_pkg::CUR_ROW_W-1:0]    rsp_cursor_row,
   output logic [tcw_pkg::CUR_COL_W-1:0]    rsp_cursor_col,
   output logic [tcw_pkg::LOC_W-1:0]        rsp_cursor_location,
   output logic [tcw_pkg::CHAR_W-1:0]       rsp_read_char,
   output logic [tcw_pkg::COLOR_W-1:0]      rsp_read_color
);

   // controller drives the sequence, datapath holds the store, cursor and
   // result register
   tcw_pkg::cmd_type cmd;
   tcw_pkg::sts_type sts;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tcw_dpath #(
      .SCREEN_ROWS (SCREEN_ROWS),
      .SCREEN_COLS (SCREEN_COLS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .req_kind            (req_kind),
      .req_char_code       (req_char_code),
      .req_color           (req_color),
      .req_cell_row        (req_cell_row),
      .req_cell_col        (req_cell_col),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_cursor_col      (rsp_cursor_col),
      .rsp_cursor_location (rsp_cursor_location),
      .rsp_read_char       (rsp_read_char),
      .rsp_read_color      (rsp_read_color)
   );

endmodule

/* sv/tcw_checker.sv */
module tcw_checker #(
   parameter int SCREEN_ROWS = 24,
   parameter int SCREEN_COLS = 80
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic [tcw_pkg::KIND_W-1:0]       req_kind,
   input logic [tcw_pkg::CHAR_W-1:0]       req_char_code,
   input logic [tcw_pkg::COLOR_W-1:0]      req_color,
   input logic [tcw_pkg::CELL_ROW_W-1:0]   req_cell_row,
   input logic [tcw_pkg::CELL_COL_W-1:0]   req_cell_col,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [tcw_pkg::CUR_ROW_W-1:0]    rsp_cursor_row,
   input logic [tcw_pkg::CUR_COL_W-1:0]    rsp_cursor_col,
   input logic [tcw_pkg::LOC_W-1:0]        rsp_cursor_location,
   input logic [tcw_pkg::CHAR_W-1:0]       rsp_read_char,
   input logic [tcw_pkg::COLOR_W-1:0]      rsp_read_color
);

   // clearing pass after reset blocks new items
   a_init_stall: assert property (@(posedge clock) $past(reset) |-> req_stall)
      else $error("item channel open during clearing pass");

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken back to back");

   // cursor column stays on screen and location agrees with the cursor
   a_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (SCREEN_ROWS <= 32) |->
         (int'(rsp_cursor_col) < SCREEN_COLS) &&
         (rsp_cursor_location ==
            tcw_pkg::LOC_W'(int'(rsp_cursor_row) * SCREEN_COLS + int'(rsp_cursor_col))))
      else $error("cursor location inconsistent");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cursor_location) &&
         $stable(rsp_read_char) && $stable(rsp_read_color))
      else $error("stalled result changed");

endmodule

bind text_console_writer_top tcw_checker #(
   .SCREEN_ROWS (SCREEN_ROWS),
   .SCREEN_COLS (SCREEN_COLS)
) u_tcw_checker (.*);
